// ===== rtl/core/wss_pkg.sv =====
// Package for the wildcard substring search block.
// Holds widths, codes, and the control struct shared by the cell row and the top level.
// No dependencies.
package wss_pkg;

  localparam int TEXT_W       = 8;
  localparam int POS_W        = 16;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_INDEX_W  = 2;
  localparam int PAT_LEN_W    = 5;
  localparam int BYTES_PER_REG = CFG_DATA_W / TEXT_W;

  localparam int DEFAULT_MAX_PATTERN_LENGTH = 16;

  localparam logic [TEXT_W-1:0] WILDCARD_BYTE = 8'h3F;
  localparam logic [POS_W-1:0]  POSITION_MAX  = 16'hFFFF;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_LOW    = 2'd0,
    CFG_PATTERN_HIGH   = 2'd1,
    CFG_PATTERN_LENGTH = 2'd2
  } cfg_index_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic              adv;
    logic              clr;
    logic [TEXT_W-1:0] text_byte;
  } wss_cell_ctl_t;

endpackage

// ===== rtl/core/wss_if.sv =====
// Channel interfaces of the wildcard substring search block.
// Text input, result output and configuration write channels with valid/ready.
// Depends on wss_pkg.
interface wss_in_if;
  logic                       valid;
  logic                       ready;
  logic [wss_pkg::TEXT_W-1:0] text_byte;
  logic                       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface wss_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [wss_pkg::POS_W-1:0] match_position;

  modport source (output valid, output found, output match_position, input ready);
  modport sink   (input valid, input found, input match_position, output ready);
endinterface

interface wss_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [wss_pkg::CFG_INDEX_W-1:0] index;
  logic [wss_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/wss_cell.sv =====
// One cell of the partial-match row: compares its pattern byte with the text byte
// and keeps the flag for "pattern bytes 0..k end at the current byte". Depends on wss_pkg.
module wss_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  wss_pkg::wss_cell_ctl_t     ctl,
  input  logic [wss_pkg::TEXT_W-1:0] pattern_byte,
  input  logic                       cell_en,
  input  logic                       prev_match,
  output logic                       match_out,
  output logic                       match_nxt
);
  import wss_pkg::*;

  logic match_r;
  logic hit;

  // A zero text byte matches nothing; the wildcard matches any other byte.
  assign hit = cell_en && (ctl.text_byte != '0) &&
               ((ctl.text_byte == pattern_byte) || (pattern_byte == WILDCARD_BYTE));

  assign match_nxt = prev_match && hit;
  assign match_out = match_r;

  // The flag moves one cell along per accepted byte and clears at end of string.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctl.adv) begin
      match_r <= ctl.clr ? 1'b0 : match_nxt;
    end
  end

endmodule

// ===== rtl/core/wss_chain.sv =====
// Row of match cells, one per pattern position, and selection of the flag at the
// last pattern position in use. Depends on wss_pkg and wss_cell.
module wss_chain #(
  parameter int MAX_LEN = wss_pkg::DEFAULT_MAX_PATTERN_LENGTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wss_pkg::wss_cell_ctl_t          ctl,
  input  logic [wss_pkg::CFG_DATA_W-1:0]  pattern_low,
  input  logic [wss_pkg::CFG_DATA_W-1:0]  pattern_high,
  input  logic [$clog2(MAX_LEN+1)-1:0]    len_eff,
  output logic                            tail_hit
);
  import wss_pkg::*;

  localparam int LW = $clog2(MAX_LEN + 1);

  logic [MAX_LEN-1:0] flag_r;
  logic [MAX_LEN-1:0] flag_nxt;

  genvar k;
  generate
    for (k = 0; k < MAX_LEN; k++) begin : g_cell
      logic [TEXT_W-1:0] pat_byte;
      logic              prev;

      // Pattern bytes past the two registers read as zero.
      if (k < BYTES_PER_REG) begin : g_low
        assign pat_byte = pattern_low[k*TEXT_W +: TEXT_W];
      end else if (k < 2*BYTES_PER_REG) begin : g_high
        assign pat_byte = pattern_high[(k-BYTES_PER_REG)*TEXT_W +: TEXT_W];
      end else begin : g_zero
        assign pat_byte = '0;
      end

      // The first cell starts a new candidate at every byte.
      if (k == 0) begin : g_head
        assign prev = 1'b1;
      end else begin : g_link
        assign prev = flag_r[k-1];
      end

      wss_cell u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .pattern_byte (pat_byte),
        .cell_en      (LW'(k) < len_eff),
        .prev_match   (prev),
        .match_out    (flag_r[k]),
        .match_nxt    (flag_nxt[k])
      );
    end
  endgenerate

  // Pick the updated flag of cell len-1; an empty pattern selects nothing.
  always_comb begin
    tail_hit = 1'b0;
    for (int i = 0; i < MAX_LEN; i++) begin
      if (len_eff == LW'(i + 1)) begin
        tail_hit = flag_nxt[i];
      end
    end
  end

endmodule

// ===== rtl/core/wildcard_substring_search.sv =====
// Wildcard substring search, top level. A string's result is shown in the cycle after its
// last byte is accepted. Throughput: one text byte per cycle while no result is stalled, set by
// the row of match cells that updates every partial-match flag in the cycle a byte arrives.
// Reset (synchronous, active low) clears the pattern registers and the search state.
// Depends on wss_pkg, wss_if and wss_chain.
module wildcard_substring_search #(
  parameter int MAX_PATTERN_LENGTH = wss_pkg::DEFAULT_MAX_PATTERN_LENGTH
) (
  input logic      clk,
  input logic      rst_n,
  wss_in_if.sink   in_chan,
  wss_out_if.source out_chan,
  wss_cfg_if.sink  cfg_chan
);
  import wss_pkg::*;

  localparam int LW = $clog2(MAX_PATTERN_LENGTH + 1);
  localparam int CW = (LW > PAT_LEN_W) ? LW : PAT_LEN_W;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] pattern_low_r;
  logic [CFG_DATA_W-1:0] pattern_high_r;
  logic [PAT_LEN_W-1:0]  pattern_len_r;

  // Search state.
  logic [POS_W-1:0] pos_r,   pos_nxt;
  logic             seen_r,  seen_nxt;
  logic [POS_W-1:0] start_r, start_nxt;

  // Result register.
  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [POS_W-1:0] out_pos_r,   out_pos_nxt;

  logic              in_ready;
  logic              in_acc;
  logic [CW-1:0]     len_wide;
  logic [LW-1:0]     len_eff;
  logic              tail_hit;
  logic [POS_W-1:0]  back;
  logic [POS_W-1:0]  cand_start;
  wss_cell_ctl_t     cell_ctl;

  // Configuration writes; the port never stalls.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r  <= '0;
      pattern_high_r <= '0;
      pattern_len_r  <= '0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_PATTERN_LOW:    pattern_low_r  <= cfg_chan.data;
        CFG_PATTERN_HIGH:   pattern_high_r <= cfg_chan.data;
        CFG_PATTERN_LENGTH: pattern_len_r  <= cfg_chan.data[PAT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // A length above the number of cells is taken as the number of cells.
  assign len_wide = CW'(pattern_len_r);
  assign len_eff  = (len_wide > CW'(MAX_PATTERN_LENGTH)) ? LW'(MAX_PATTERN_LENGTH)
                                                         : LW'(len_wide);

  // Input handshake: a byte is taken while the result register is free or draining.
  assign in_ready       = !out_valid_r || out_chan.ready;
  assign in_chan.ready  = in_ready;
  assign in_acc         = in_chan.valid && in_ready;

  assign cell_ctl.adv       = in_acc;
  assign cell_ctl.clr       = in_chan.last_byte;
  assign cell_ctl.text_byte = in_chan.text_byte;

  wss_chain #(
    .MAX_LEN (MAX_PATTERN_LENGTH)
  ) u_chain (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (cell_ctl),
    .pattern_low  (pattern_low_r),
    .pattern_high (pattern_high_r),
    .len_eff      (len_eff),
    .tail_hit     (tail_hit)
  );

  // Start offset of a match that ends at the current byte, floored at zero.
  assign back       = POS_W'(len_eff) - POS_W'(1);
  assign cand_start = (pos_r >= back) ? (pos_r - back) : '0;

  // Next search state and result.
  always_comb begin
    pos_nxt       = pos_r;
    seen_nxt      = seen_r;
    start_nxt     = start_r;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    if (in_acc) begin
      if (tail_hit && !seen_r) begin
        seen_nxt  = 1'b1;
        start_nxt = cand_start;
      end
      if (pos_r != POSITION_MAX) begin
        pos_nxt = pos_r + POS_W'(1);
      end
      if (in_chan.last_byte) begin
        out_valid_nxt = 1'b1;
        out_found_nxt = seen_nxt;
        out_pos_nxt   = seen_nxt ? start_nxt : '0;
        pos_nxt       = '0;
        seen_nxt      = 1'b0;
        start_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      seen_r      <= 1'b0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      seen_r      <= seen_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.found          = out_found_r;
  assign out_chan.match_position = out_pos_r;

`ifndef SYNTHESIS
  // The last byte of a string yields a result and leaves a cleared search.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_chan.last_byte |=> out_valid_r && (pos_r == '0) && !seen_r)
    else $error("end of string did not produce a result or clear the search");

  // A result without a match reports offset zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> (out_pos_r == '0))
    else $error("match position nonzero on a result without a match");

  // A stalled result blocks new bytes.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |-> !in_chan.ready)
    else $error("byte accepted while the result register is full");

  // The byte offset saturates.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_chan.last_byte && (pos_r == POSITION_MAX) |=> (pos_r == POSITION_MAX))
    else $error("byte offset wrapped past its maximum");

  // Only the first match of a string is kept.
  assert property (@(posedge clk) disable iff (!rst_n)
    seen_r && !(in_acc && in_chan.last_byte) |=> seen_r && $stable(start_r))
    else $error("first match start changed within a string");
`endif

endmodule
